// File: rtl/core/sliding_median_filter_macros.svh
`ifndef SLIDING_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_MACROS_SVH

// Check a property on every clock edge outside of reset
`define SMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

    localparam int SAMPLE_W            = 32;
    localparam int HALF_WINDOW_W       = 3;
    localparam int MAX_HALF_WINDOW_DEF = 7;

    localparam logic [HALF_WINDOW_W-1:0] HALF_WINDOW_RESET = 3'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// File: rtl/core/sliding_median_filter.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                                 Transfer
// s_*       in         tdata = sample, tlast = is_last         s_tvalid & s_tready
// m_*       out        tdata = median_value, tlast = last_out  m_tvalid & m_tready
// cfg_*     in         cfg_data = half_window                  cfg_valid & cfg_ready
//
// One sample is taken per cycle while s_tready is high; its result is registered in the work
// registers and then in the output register before it is valid on m_*.
// A flagged last sample makes the median unit release min(h, n-1) + 1 results (h the
// half window, n the samples in the run), one result per cycle while the output is not
// stalled, and s_tready stays low until the final one. The median is a combinational rank
// compare over the clipped window of up to 2*h+1 history taps.
// Reset clears the sample count, the pending work and the output valid flag;
// half_window returns to 3. A stalled output holds its result while the input
// still takes samples until the median unit has work waiting.

module sliding_median_filter #(
    parameter int MAX_HALF_WINDOW = smf_pkg::MAX_HALF_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [smf_pkg::SAMPLE_W-1:0]       s_tdata,   // [31:0] sample
    input  logic                               s_tlast,   // is_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [smf_pkg::SAMPLE_W-1:0]       m_tdata,   // [31:0] median_value
    output logic                               m_tlast,   // last_out
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [smf_pkg::HALF_WINDOW_W-1:0]  cfg_data   // [2:0] half_window
);
    import smf_pkg::*;

    localparam int HIST_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int SEEN_W     = $clog2(HIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(HIST_DEPTH);
    localparam int HW_W       = $clog2(MAX_HALF_WINDOW + 1);

    sample_t                    hist_reg [HIST_DEPTH];
    logic [SEEN_W-1:0]          seen_reg;
    logic [SEEN_W-1:0]          seen_next;
    logic [HALF_WINDOW_W-1:0]   half_window_reg;
    logic [HW_W-1:0]            h_eff;

    logic                       job_valid_reg;
    logic [HW_W-1:0]            job_d_reg;
    logic [HW_W-1:0]            job_h_reg;
    logic [SEEN_W-1:0]          job_seen_reg;
    logic                       job_last_reg;

    logic                       out_valid_reg;
    sample_t                    out_data_reg;
    logic                       out_last_reg;

    logic                       in_fire;
    logic                       job_start;
    logic [HW_W-1:0]            start_d;
    logic                       out_load;
    logic                       job_fire;
    logic                       job_done;

    logic [IDX_W-1:0]           reach;
    logic [IDX_W-1:0]           seen_m1;
    logic [IDX_W-1:0]           hi_idx;
    logic [IDX_W-1:0]           med_idx;
    logic [HIST_DEPTH-1:0]      in_win;
    logic [HIST_DEPTH-1:0]      beats [HIST_DEPTH];
    logic [IDX_W-1:0]           rank [HIST_DEPTH];
    sample_t                    med_value;

    // Limit the half window to what the history holds
    assign h_eff = (half_window_reg > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                       : HW_W'(half_window_reg);

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_load  = !out_valid_reg || m_tready;
    assign job_fire  = job_valid_reg && out_load;
    assign job_done  = job_fire && (!job_last_reg || (job_d_reg == '0));
    assign s_tready  = !job_valid_reg || job_done;

    // Count samples of the run, saturating at the history depth
    assign seen_next = (seen_reg == SEEN_W'(HIST_DEPTH)) ? seen_reg : seen_reg + 1'b1;

    // Decide whether this sample releases results, and the first center lag
    always_comb
    begin
        if (s_tlast)
        begin
            start_d = (SEEN_W'(h_eff) < (seen_next - 1'b1)) ? h_eff
                                                             : HW_W'(seen_next - 1'b1);
        end
        else
        begin
            start_d = h_eff;
        end
        job_start = in_fire && (s_tlast || (seen_next > SEEN_W'(h_eff)));
    end

    // Window spans lags 0 .. min(d+h, seen-1); take the upper median
    assign reach   = IDX_W'(job_d_reg) + IDX_W'(job_h_reg);
    assign seen_m1 = IDX_W'(job_seen_reg - 1'b1);
    assign hi_idx  = (reach < seen_m1) ? reach : seen_m1;
    assign med_idx = IDX_W'((SEEN_W'(hi_idx) + 1'b1) >> 1);

    // Rank each tap against the others, ties broken by lag, and pick the middle one
    always_comb
    begin
        med_value = '0;
        for (int j = 0; j < HIST_DEPTH; j++)
        begin
            in_win[j] = (IDX_W'(j) <= hi_idx);
        end
        for (int j = 0; j < HIST_DEPTH; j++)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                beats[j][k] = in_win[k] && ((hist_reg[k] < hist_reg[j]) ||
                              ((hist_reg[k] == hist_reg[j]) && (k < j)));
            end
            rank[j] = IDX_W'($countones(beats[j]));
            if (in_win[j] && (rank[j] == med_idx))
            begin
                med_value = med_value | hist_reg[j];
            end
        end
    end

    // Shift the history on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hist_reg[0] <= $signed(s_tdata);
            for (int k = 1; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_window_reg <= HALF_WINDOW_RESET;
            seen_reg        <= '0;
            job_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                half_window_reg <= cfg_data;
            end
            if (in_fire)
            begin
                seen_reg <= s_tlast ? '0 : seen_next;
            end
            if (job_start)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
            end
            if (job_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load new work or advance the drain of a last sample
    always_ff @(posedge clk)
    begin
        if (job_start)
        begin
            job_d_reg    <= start_d;
            job_h_reg    <= h_eff;
            job_seen_reg <= seen_next;
            job_last_reg <= s_tlast;
        end
        else if (job_fire && !job_done)
        begin
            job_d_reg <= job_d_reg - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (job_fire)
        begin
            out_data_reg <= med_value;
            out_last_reg <= job_last_reg && (job_d_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/core/smf_checker.sv
`timescale 1ns / 1ps
`include "sliding_median_filter_macros.svh"

module smf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [smf_pkg::SAMPLE_W-1:0]  m_tdata,
    input logic                          m_tlast
);
    import smf_pkg::*;

    // Hold a stalled result unchanged
    `SMF_ASSERT(a_out_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "stalled result changed")

    // Keep the output empty after an edge that sees reset asserted
    `SMF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid, "output valid after reset")

    // A last sample always releases at least one result
    `SMF_ASSERT(a_last_releases,
        s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid,
        "last sample released no result")

endmodule

bind sliding_median_filter smf_checker u_smf_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import smf_pkg::*;

    localparam int MAX_HW       = smf_pkg::MAX_HALF_WINDOW_DEF;
    localparam int HIST_DEPTH   = 2 * MAX_HW + 1;
    // A flagged last sample occupies the median unit for up to MAX_HW+1 results
    localparam int DRAIN_CYCLES = 2 * MAX_HW + 8;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_CYCLES  = 64;
    localparam int HOLD_AFTER   = 30;
    localparam int HOLD_FEED    = 12;
    localparam int PHASE_ITEMS  = 18;

    typedef struct packed {
        sample_t sample;
        logic    is_last;
    } sample_item_t;

    typedef struct packed {
        sample_t median;
        logic    last;
    } median_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [SAMPLE_W-1:0]      s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [SAMPLE_W-1:0]      m_tdata;
    logic                     m_tlast;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [HALF_WINDOW_W-1:0] cfg_data = '0;

    // Stimulus and expectation stores
    sample_item_t   sample_feed_q[$];
    median_result_t median_expect_q[$];
    sample_item_t   next_item;
    logic           steady = 1'b0;
    int             median_errors = 0;
    int             medians_checked = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;

    // Filter state mirror
    sample_t history_taps [HIST_DEPTH];
    int      samples_held = 0;
    int      half_window_cfg = int'(HALF_WINDOW_RESET);

    sliding_median_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sort the clipped window around a lag and queue its upper median
    function automatic void queue_median(int center, int h, logic last);
        sample_t        sorted [HIST_DEPTH];
        sample_t        x;
        median_result_t r;
        int             lo;
        int             hi;
        int             m;
        int             a;
        lo = (center > h) ? center - h : 0;
        hi = center + h;
        if (samples_held > 0 && hi > samples_held - 1)
            hi = samples_held - 1;
        m = 0;
        for (int k = lo; k <= hi && k < HIST_DEPTH; k++)
        begin
            x = history_taps[k];
            a = m;
            while (a > 0 && sorted[a-1] > x)
            begin
                sorted[a] = sorted[a-1];
                a--;
            end
            sorted[a] = x;
            m++;
        end
        r.median = (m == 0) ? '0 : sorted[m/2];
        r.last   = last;
        median_expect_q = {median_expect_q, r};
    endfunction

    // Advance the history by one sample and queue every median it releases
    function automatic void predict_medians(sample_t s, logic is_last);
        int h;
        int d;
        h = (half_window_cfg > MAX_HW) ? MAX_HW : half_window_cfg;
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            history_taps[k] = history_taps[k-1];
        history_taps[0] = s;
        if (samples_held < HIST_DEPTH)
            samples_held++;
        if (is_last)
        begin
            d = (h < samples_held - 1) ? h : samples_held - 1;
            for (int c = d; c >= 0; c--)
                queue_median(c, h, c == 0);
            samples_held = 0;
        end
        else if (samples_held > h)
        begin
            queue_median(h, h, 1'b0);
        end
    endfunction

    // Sample driver: predict on each transfer, then offer the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_medians(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (sample_feed_q.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = sample_feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.sample;
                    s_tlast  <= next_item.is_last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off: once, with a batch of samples waiting, refuse results for a while
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && medians_checked >= HOLD_AFTER &&
                 sample_feed_q.size() >= HOLD_FEED)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Result monitor: check each transfer against the oldest expected median
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (median_expect_q.size() == 0)
                begin
                    $error("unexpected result: median_value %0d last_out %0b",
                           $signed(m_tdata), m_tlast);
                    median_errors++;
                end
                else
                begin
                    if (m_tdata !== median_expect_q[0].median)
                    begin
                        $error("median_value: expected %0d, got %0d",
                               median_expect_q[0].median, $signed(m_tdata));
                        median_errors++;
                    end
                    if (m_tlast !== median_expect_q[0].last)
                    begin
                        $error("last_out: expected %0b, got %0b",
                               median_expect_q[0].last, m_tlast);
                        median_errors++;
                    end
                    void'(median_expect_q.pop_front());
                end
                medians_checked++;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic add_sample(sample_t s, logic is_last);
        sample_item_t it;
        it.sample  = s;
        it.is_last = is_last;
        sample_feed_q = {sample_feed_q, it};
    endtask

    // Wait until every sample is taken and every median has come out
    task automatic settle();
        @(negedge clk);
        while (sample_feed_q.size() != 0 || s_tvalid)
            @(negedge clk);
        while (median_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_half_window(logic [HALF_WINDOW_W-1:0] v);
        @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        half_window_cfg = int'(v);
    endtask

    initial
    begin
        logic [HALF_WINDOW_W-1:0] hw_plan [5];
        int      run_left;
        int      kind;
        sample_t s;

        foreach (history_taps[i])
            history_taps[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset half window: one-sample run, then a run of extremes
        add_sample(32'sh12345678, 1'b1);
        add_sample(32'sh80000000, 1'b0);
        add_sample(32'sh7fffffff, 1'b0);
        add_sample(32'sh00000000, 1'b0);
        add_sample(32'shffffffff, 1'b0);
        add_sample(32'sh00000001, 1'b0);
        add_sample(32'sh80000000, 1'b0);
        add_sample(32'sh7fffffff, 1'b1);
        settle();

        // Zero half window passes samples straight through
        write_half_window(3'd0);
        add_sample(-32'sd5, 1'b0);
        add_sample(32'sd9, 1'b0);
        add_sample(32'sh7fffffff, 1'b1);
        settle();

        // Widest window, then shrink it in the middle of a run
        write_half_window(3'd7);
        add_sample(32'sd40, 1'b0);
        add_sample(-32'sd3, 1'b0);
        add_sample(32'sd17, 1'b0);
        add_sample(32'sd17, 1'b0);
        add_sample(32'sh80000000, 1'b0);
        settle();
        write_half_window(3'd1);
        add_sample(32'sd2, 1'b0);
        add_sample(32'sh7fffffff, 1'b0);
        add_sample(-32'sd1, 1'b1);
        settle();

        // Even-sized edge set selects the upper median
        write_half_window(3'd2);
        add_sample(32'sd10, 1'b0);
        add_sample(32'sd20, 1'b1);
        settle();

        // Random runs under several half windows
        hw_plan[0] = 3'd7;
        hw_plan[1] = 3'd0;
        hw_plan[2] = 3'($urandom_range(1, 6));
        hw_plan[3] = 3'($urandom_range(1, 6));
        hw_plan[4] = 3'd5;
        run_left = 0;
        for (int p = 0; p < 5; p++)
        begin
            write_half_window(hw_plan[p]);
            steady = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (run_left == 0)
                    run_left = $urandom_range(1, 20);
                kind = $urandom_range(3);
                case (kind)
                    0: s = sample_t'($urandom_range(16)) - 32'sd8;
                    1:
                    begin
                        case ($urandom_range(3))
                            0: s = 32'sh80000000;
                            1: s = 32'sh7fffffff;
                            2: s = 32'sh00000000;
                            default: s = 32'shffffffff;
                        endcase
                    end
                    default: s = sample_t'($urandom);
                endcase
                add_sample(s, run_left == 1);
                run_left--;
            end
            settle();
        end
        steady = 1'b0;

        if (median_errors == 0 && median_expect_q.size() == 0)
            $display("sliding_median_filter: match");
        else
            $display("sliding_median_filter: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("sliding_median_filter: mismatch");
        $finish;
    end

endmodule
